// ===== hw/rtl/rtpfua_pkg.sv =====
// rtpfua_pkg: shared types and constants of the rtp h.264 fu-a depacketizer
// no dependencies; imported by every module of the block

package rtpfua_pkg;

    localparam int RTP_HEADER_BYTES = 12;
    localparam int LENGTH_BITS      = 23;
    localparam int RUN_BYTES        = 5;

    localparam logic [LENGTH_BITS-1:0] MAX_UNIT_LENGTH_RESET = LENGTH_BITS'(5184000);
    localparam logic                   SKIP_UNTIL_MARKER_RESET = 1'b1;

    // configuration register indexes
    localparam logic CFG_SKIP_UNTIL_MARKER = 1'b0;
    localparam logic CFG_MAX_UNIT_LENGTH   = 1'b1;

    // byte positions within a packet
    localparam logic [3:0] POS_START   = 4'd0;
    localparam logic [3:0] POS_MARKER  = 4'd1;
    localparam logic [3:0] POS_SEQ_HI  = 4'd2;
    localparam logic [3:0] POS_SEQ_LO  = 4'd3;
    localparam logic [3:0] POS_TS_HI   = 4'd4;
    localparam logic [3:0] POS_TS_LO   = 4'd7;
    localparam logic [3:0] POS_NAL     = 4'(RTP_HEADER_BYTES);
    localparam logic [3:0] POS_FU      = 4'(RTP_HEADER_BYTES + 1);
    localparam logic [3:0] POS_SAT     = 4'(RTP_HEADER_BYTES + 2);

    localparam logic [4:0] NAL_TYPE_FU_A = 5'h1c;

    typedef enum logic
    {
        KIND_STREAM_BYTE = 1'b0,
        KIND_DESCRIPTOR  = 1'b1
    } out_kind_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed
    {
        out_kind_t              out_kind;
        logic [7:0]             out_byte;
        logic [15:0]            unit_seq;
        logic [31:0]            unit_timestamp;
        logic [LENGTH_BITS-1:0] unit_length;
        logic                   unit_overflow;
        logic                   last_of_run;
    } result_item_t;

    // all results caused by one input item
    typedef struct packed
    {
        logic [RUN_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      desc;
        logic [15:0]               seq;
        logic [31:0]               timestamp;
        logic [LENGTH_BITS-1:0]    length;
        logic                      overflow;
    } run_t;

endpackage

// ===== hw/rtl/rtpfua_parse.sv =====
// rtpfua_parse: packet state, header capture and unit bookkeeping per byte
// depends on rtpfua_pkg; feeds a result run to rtpfua_emit

module rtpfua_parse
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_accept,
    input  rtpfua_pkg::byte_item_t         item,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [rtpfua_pkg::LENGTH_BITS-1:0] cfg_data,
    output logic                           run_load,
    output rtpfua_pkg::run_t               run
);
    import rtpfua_pkg::*;

    typedef enum logic [1:0]
    {
        FU_SINGLE = 2'd0,
        FU_START  = 2'd1,
        FU_MIDDLE = 2'd2,
        FU_END    = 2'd3
    } fu_kind_t;

    logic                   syncing_reg, syncing_next;
    logic [3:0]             pos_reg, pos_next;
    logic                   new_unit_reg, new_unit_next;
    logic                   marker_reg, marker_next;
    logic [2:0]             nal_reg, nal_next;
    fu_kind_t               fu_reg, fu_next;
    logic [15:0]            held_seq_reg, held_seq_next;
    logic [31:0]            held_ts_reg, held_ts_next;
    logic [15:0]            pkt_seq_reg, pkt_seq_next;
    logic [31:0]            pkt_ts_reg, pkt_ts_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [LENGTH_BITS-1:0] max_len_reg;

    logic [7:0]             b;
    logic                   open_try;
    logic                   open_now;
    logic                   start_code;
    logic                   has_tail;
    logic [7:0]             tail;
    logic [2:0]             base;
    logic [2:0]             nbytes;
    logic [LENGTH_BITS-1:0] len_base;
    logic                   ovf_base;
    logic [LENGTH_BITS:0]   len_sum;
    logic                   desc;

    always_comb
    begin
        b             = item.data_byte;
        syncing_next  = syncing_reg;
        marker_next   = marker_reg;
        nal_next      = nal_reg;
        fu_next       = fu_reg;
        pkt_seq_next  = pkt_seq_reg;
        pkt_ts_next   = pkt_ts_reg;
        open_try      = 1'b0;
        start_code    = 1'b0;
        has_tail      = 1'b0;
        tail          = b;

        case (pos_reg) inside
            POS_START:
            begin
                marker_next = 1'b0;
            end
            POS_MARKER:
            begin
                marker_next = b[7];
            end
            POS_SEQ_HI, POS_SEQ_LO:
            begin
                pkt_seq_next = {pkt_seq_reg[7:0], b};
            end
            [POS_TS_HI:POS_TS_LO]:
            begin
                pkt_ts_next = {pkt_ts_reg[23:0], b};
            end
            POS_NAL:
            begin
                if (!syncing_reg)
                begin
                    nal_next = b[7:5];
                    if (b[4:0] == NAL_TYPE_FU_A)
                    begin
                        fu_next = FU_MIDDLE;
                    end
                    else
                    begin
                        fu_next    = FU_SINGLE;
                        open_try   = 1'b1;
                        start_code = 1'b1;
                        has_tail   = 1'b1;
                    end
                end
            end
            POS_FU:
            begin
                if (!syncing_reg)
                begin
                    if (fu_reg == FU_SINGLE)
                    begin
                        has_tail = 1'b1;
                    end
                    else
                    begin
                        open_try = 1'b1;
                        if (b[7])
                        begin
                            fu_next    = FU_START;
                            start_code = 1'b1;
                            has_tail   = 1'b1;
                            tail       = {nal_reg, b[4:0]};
                        end
                        else if (b[6])
                        begin
                            fu_next = FU_END;
                        end
                        else
                        begin
                            fu_next = FU_MIDDLE;
                        end
                    end
                end
            end
            [POS_SAT:4'd15]:
            begin
                has_tail = !syncing_reg;
            end
            default:
            begin
            end
        endcase

        open_now = open_try && new_unit_reg;
        base     = {2'b00, open_now};
        nbytes   = base + (start_code ? 3'd3 : 3'd0) + {2'b00, has_tail};

        run.bytes = '0;
        if (start_code)
        begin
            run.bytes[base + 3'd2] = 8'h01;
            run.bytes[base + 3'd3] = tail;
        end
        else if (has_tail)
        begin
            run.bytes[base] = tail;
        end

        held_seq_next = open_now ? pkt_seq_reg : held_seq_reg;
        held_ts_next  = open_now ? pkt_ts_reg : held_ts_reg;
        len_base      = open_now ? '0 : len_reg;
        ovf_base      = open_now ? 1'b0 : ovf_reg;
        len_sum       = {1'b0, len_base} + (LENGTH_BITS+1)'(nbytes);

        // saturating length over all bytes of this item
        len_next = len_base;
        ovf_next = ovf_base;
        if (nbytes != 3'd0)
        begin
            if (len_base >= max_len_reg)
            begin
                ovf_next = 1'b1;
            end
            else if (len_sum > {1'b0, max_len_reg})
            begin
                len_next = max_len_reg;
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_sum[LENGTH_BITS-1:0];
            end
        end

        desc          = 1'b0;
        new_unit_next = open_now ? 1'b0 : new_unit_reg;
        if (item.last_byte)
        begin
            if (syncing_reg)
            begin
                if (marker_next)
                begin
                    syncing_next  = 1'b0;
                    new_unit_next = 1'b1;
                end
            end
            else if (marker_next &&
                     ((fu_next == FU_SINGLE && pos_reg >= POS_NAL) ||
                      (fu_next == FU_END && pos_reg >= POS_FU)))
            begin
                desc          = 1'b1;
                new_unit_next = 1'b1;
            end
            pos_next = POS_START;
        end
        else
        begin
            pos_next = (pos_reg >= POS_SAT) ? POS_SAT : pos_reg + 4'd1;
        end

        run.nbytes    = nbytes;
        run.desc      = desc;
        run.seq       = held_seq_next;
        run.timestamp = held_ts_next;
        run.length    = len_next;
        run.overflow  = ovf_next;
        run_load      = item_accept && (nbytes != 3'd0 || desc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syncing_reg  <= SKIP_UNTIL_MARKER_RESET;
            max_len_reg  <= MAX_UNIT_LENGTH_RESET;
            pos_reg      <= POS_START;
            new_unit_reg <= 1'b0;
            marker_reg   <= 1'b0;
            nal_reg      <= '0;
            fu_reg       <= FU_SINGLE;
            held_seq_reg <= '0;
            held_ts_reg  <= '0;
            pkt_seq_reg  <= '0;
            pkt_ts_reg   <= '0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SKIP_UNTIL_MARKER: syncing_reg <= cfg_data[0];
                    CFG_MAX_UNIT_LENGTH:   max_len_reg <= cfg_data;
                    default:               max_len_reg <= max_len_reg;
                endcase
            end
            if (item_accept)
            begin
                if (!(cfg_write && cfg_index == CFG_SKIP_UNTIL_MARKER))
                begin
                    syncing_reg <= syncing_next;
                end
                pos_reg      <= pos_next;
                new_unit_reg <= new_unit_next;
                marker_reg   <= marker_next;
                nal_reg      <= nal_next;
                fu_reg       <= fu_next;
                held_seq_reg <= held_seq_next;
                held_ts_reg  <= held_ts_next;
                pkt_seq_reg  <= pkt_seq_next;
                pkt_ts_reg   <= pkt_ts_next;
                len_reg      <= len_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

endmodule

// ===== hw/rtl/rtpfua_emit.sv =====
// rtpfua_emit: result run register, hands out one result item per cycle while result_stall is low
// depends on rtpfua_pkg; loaded by rtpfua_parse

module rtpfua_emit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     run_load,
    input  rtpfua_pkg::run_t         run,
    output logic                     busy,
    output logic                     result_valid,
    input  logic                     result_stall,
    output rtpfua_pkg::result_item_t result_item
);
    import rtpfua_pkg::*;

    run_t       run_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic [2:0] total;
    logic       is_last;
    logic       fire;

    always_comb
    begin
        total        = run_reg.nbytes + {2'b00, run_reg.desc};
        is_last      = (idx_reg == total - 3'd1);
        result_valid = valid_reg;
        fire         = valid_reg && !result_stall;
        busy         = valid_reg && !(fire && is_last);

        result_item             = '0;
        result_item.last_of_run = is_last;
        if (idx_reg < run_reg.nbytes)
        begin
            result_item.out_kind = KIND_STREAM_BYTE;
            result_item.out_byte = run_reg.bytes[idx_reg];
        end
        else
        begin
            result_item.out_kind       = KIND_DESCRIPTOR;
            result_item.unit_seq       = run_reg.seq;
            result_item.unit_timestamp = run_reg.timestamp;
            result_item.unit_length    = run_reg.length;
            result_item.unit_overflow  = run_reg.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (run_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_load)
        begin
            run_reg <= run;
        end
    end

endmodule

// ===== hw/rtl/rtp_h264_fua_depacketizer.sv =====
// rtp_h264_fua_depacketizer: top level, rtp payload bytes in, annex-b stream and unit descriptors out
// depends on rtpfua_pkg, rtpfua_parse, rtpfua_emit

// Takes one RTP payload byte per cycle unless stalled (12-byte header assumed) and turns single NAL
// and FU-A packets into an Annex B byte stream with a descriptor after each access
// unit. A byte that causes no result, or one result that is taken at once, does not stall
// the input; a byte that causes more results (start codes, the extra leading zero of a unit,
// the closing descriptor; at most 6) holds the input stalled until its run has left,
// because the results of one byte sit in a single run register that is drained
// one result per cycle while result_stall is low. The next byte is taken in the
// cycle the last result of a run is taken. Configuration writes are always ready;
// write them only while the block is idle. Register 0 skip_until_marker also
// restarts marker sync, register 1 is max_unit_length.

module rtp_h264_fua_depacketizer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  rtpfua_pkg::byte_item_t             byte_item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output rtpfua_pkg::result_item_t           result_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [rtpfua_pkg::LENGTH_BITS-1:0] cfg_data
);
    import rtpfua_pkg::*;

    logic busy;
    logic run_load;
    run_t run;

    assign byte_stall = busy;
    assign cfg_ready  = 1'b1;

    rtpfua_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (byte_valid && !busy),
        .item        (byte_item),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .run_load    (run_load),
        .run         (run)
    );

    rtpfua_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_load     (run_load),
        .run          (run),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== hw/rtl/rtpfua_checker.sv =====
// rtpfua_checker: port-level assertions for the depacketizer
// depends on rtpfua_pkg; bound to rtp_h264_fua_depacketizer

module rtpfua_checker
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     byte_stall,
    input logic                     result_valid,
    input logic                     result_stall,
    input rtpfua_pkg::result_item_t result_item
);
    import rtpfua_pkg::*;

    // input only waits on a pending run
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // a run does not stop before its last result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result_item.last_of_run |=> result_valid)
        else $error("run ended early");

    // the descriptor always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.out_kind == KIND_DESCRIPTOR |-> result_item.last_of_run)
        else $error("descriptor not last of run");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result changed");

endmodule

bind rtp_h264_fua_depacketizer rtpfua_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
